### rtl/dtp_pkg.sv
// Package with the types, widths and register codes of the disparity reprojection block.
package dtp_pkg;

  localparam int NSTEP = 24;
  localparam int DEN_W = 21;
  localparam int CFG_W = 20;
  localparam int OUT_W = 24;

  typedef enum logic [2:0] {
    REG_BASELINE = 3'd0,
    REG_FOCAL    = 3'd1,
    REG_DOFFS    = 3'd2,
    REG_CX       = 3'd3,
    REG_CY       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [OUT_W-1:0] work;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic             pv;
    logic             neg_x;
    logic             neg_y;
    logic [DEN_W-1:0] den;
    lane_t            lz;
    lane_t            lx;
    lane_t            ly;
  } beat_t;

endpackage

### rtl/dtp_ifs.sv
// Stream interfaces for the pixel input and the point output.
interface dtp_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] disparity;
  logic [11:0] column;
  logic [11:0] row;
  modport source (output valid, disparity, column, row, input ready);
  modport sink (input valid, disparity, column, row, output ready);
endinterface

interface dtp_pt_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic [23:0]        point_z;
  logic               point_valid;
  modport source (output valid, point_x, point_y, point_z, point_valid, input ready);
  modport sink (input valid, point_x, point_y, point_z, point_valid, output ready);
endinterface

### rtl/dtp_front.sv
// Front stage: forms the denominator, the numerators and the divider start values.
module dtp_front
  import dtp_pkg::*;
#(
  parameter int MAX_COLS = 4096,
  parameter int MAX_ROWS = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             take,
  input  logic [15:0]      disparity,
  input  logic [11:0]      column,
  input  logic [11:0]      row,
  input  logic [CFG_W-1:0] baseline_len,
  input  logic [CFG_W-1:0] focal_len,
  input  logic [CFG_W-1:0] disp_offset,
  input  logic [CFG_W-1:0] center_x,
  input  logic [CFG_W-1:0] center_y,
  output beat_t            beat
);

  localparam logic [16:0] COL_LIM = 17'(MAX_COLS - 1);
  localparam logic [16:0] ROW_LIM = 17'(MAX_ROWS - 1);

  logic [11:0]        col_c;
  logic [11:0]        row_c;
  logic [CFG_W-1:0]   sc_x;
  logic [CFG_W-1:0]   sc_y;
  logic [CFG_W-1:0]   mag_x;
  logic [CFG_W-1:0]   mag_y;
  logic [2*CFG_W-1:0] num_x;
  logic [2*CFG_W-1:0] num_y;
  logic [2*CFG_W-1:0] num_z;
  logic [DEN_W-1:0]   den;
  beat_t              beat_next;

  function automatic lane_t start_lane(input logic [2*CFG_W-1:0] num,
                                       input logic [DEN_W-1:0] d);
    lane_t l;
    l.rem  = DEN_W'(num[2*CFG_W-1:OUT_W]);
    l.work = num[OUT_W-1:0];
    l.ovf  = DEN_W'(num[2*CFG_W-1:OUT_W]) >= d;
    return l;
  endfunction

  always_comb begin
    col_c = ({5'b0, column} > COL_LIM) ? COL_LIM[11:0] : column;
    row_c = ({5'b0, row} > ROW_LIM) ? ROW_LIM[11:0] : row;
    sc_x  = {2'b0, col_c, 6'b0} + {4'b0, col_c, 4'b0};
    sc_y  = {2'b0, row_c, 6'b0} + {4'b0, row_c, 4'b0};
    mag_x = (sc_x < center_x) ? center_x - sc_x : sc_x - center_x;
    mag_y = (sc_y < center_y) ? center_y - sc_y : sc_y - center_y;
    num_x = mag_x * baseline_len;
    num_y = mag_y * baseline_len;
    num_z = baseline_len * focal_len;
    den   = {5'b0, disparity} + {1'b0, disp_offset};
    beat_next.valid = take;
    beat_next.pv    = den != '0;
    beat_next.neg_x = sc_x < center_x;
    beat_next.neg_y = sc_y < center_y;
    beat_next.den   = den;
    beat_next.lz    = start_lane(num_z, den);
    beat_next.lx    = start_lane(num_x, den);
    beat_next.ly    = start_lane(num_y, den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (advance) begin
      beat <= beat_next;
    end
  end

endmodule

### rtl/dtp_div_cell.sv
// Divider cell: produces one quotient bit for each of the three lanes.
module dtp_div_cell
  import dtp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  beat_t beat_in,
  output beat_t beat_out
);

  beat_t beat_next;

  function automatic lane_t step(input lane_t l, input logic [DEN_W-1:0] d);
    lane_t    o;
    logic [DEN_W:0] r2;
    logic     ge;
    r2 = {l.rem, l.work[OUT_W-1]};
    ge = r2 >= {1'b0, d};
    o.rem  = ge ? DEN_W'(r2 - {1'b0, d}) : r2[DEN_W-1:0];
    o.work = {l.work[OUT_W-2:0], ge};
    o.ovf  = l.ovf;
    return o;
  endfunction

  always_comb begin
    beat_next    = beat_in;
    beat_next.lz = step(beat_in.lz, beat_in.den);
    beat_next.lx = step(beat_in.lx, beat_in.den);
    beat_next.ly = step(beat_in.ly, beat_in.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else if (advance) begin
      beat_out <= beat_next;
    end
  end

endmodule

### rtl/disparity_to_3d_point_top.sv
// Top level: configuration registers, divider chain and saturating output register.
// Path: an accepted pixel passes the front register, the 24 divider cells and the output register.
// Throughput: one pixel per cycle; the 24 divider cells each settle one quotient bit.
// The whole chain holds while the output register is full and not taken.
// Reset is synchronous: configuration returns to its reset values, the pipeline empties.
// No memory, so no clearing pass after reset.
module disparity_to_3d_point_top
  import dtp_pkg::*;
#(
  parameter int MAX_COLS = 4096,
  parameter int MAX_ROWS = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  dtp_pix_if.sink          pix,
  dtp_pt_if.source         pt
);

  logic [CFG_W-1:0]   baseline_len;
  logic [CFG_W-1:0]   focal_len;
  logic [CFG_W-1:0]   disp_offset;
  logic [CFG_W-1:0]   center_x;
  logic [CFG_W-1:0]   center_y;
  logic               advance;
  beat_t              chain [0:NSTEP];
  beat_t              last;
  logic [OUT_W-1:0]   qz;
  logic [OUT_W-1:0]   qx;
  logic [OUT_W-1:0]   qy;
  logic [OUT_W-1:0]   z_next;
  logic [OUT_W-1:0]   x_next;
  logic [OUT_W-1:0]   y_next;

  function automatic logic [OUT_W-1:0] lateral(input logic [OUT_W-1:0] q, input logic neg);
    logic [OUT_W-1:0] r;
    if (neg) begin
      r = (q > 24'd8388608) ? 24'h800000 : (24'd0 - q);
    end else begin
      r = (q > 24'd8388607) ? 24'h7FFFFF : q;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_len <= '0;
      focal_len    <= 20'd16;
      disp_offset  <= '0;
      center_x     <= '0;
      center_y     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASELINE: baseline_len <= cfg_data;
        REG_FOCAL:    focal_len    <= cfg_data;
        REG_DOFFS:    disp_offset  <= cfg_data;
        REG_CX:       center_x     <= cfg_data;
        REG_CY:       center_y     <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign advance   = !pt.valid || pt.ready;
  assign pix.ready = advance;

  dtp_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .take         (pix.valid),
    .disparity    (pix.disparity),
    .column       (pix.column),
    .row          (pix.row),
    .baseline_len (baseline_len),
    .focal_len    (focal_len),
    .disp_offset  (disp_offset),
    .center_x     (center_x),
    .center_y     (center_y),
    .beat         (chain[0])
  );

  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    dtp_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  assign last = chain[NSTEP];

  always_comb begin
    qz = last.lz.ovf ? '1 : last.lz.work;
    qx = last.lx.ovf ? '1 : last.lx.work;
    qy = last.ly.ovf ? '1 : last.ly.work;
    z_next = last.pv ? qz : '0;
    x_next = last.pv ? lateral(qx, last.neg_x) : '0;
    y_next = last.pv ? lateral(qy, last.neg_y) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt.valid <= 1'b0;
    end else if (advance) begin
      pt.valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pt.point_z     <= z_next;
      pt.point_x     <= x_next;
      pt.point_y     <= y_next;
      pt.point_valid <= last.pv;
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    pt.valid && !pt.point_valid |-> pt.point_z == '0 && pt.point_x == '0 && pt.point_y == '0)
    else $error("point without denominator carries nonzero coordinates");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(chain[0]) && $stable(last))
    else $error("divider chain moved during a stall");

  a_zero_base: assert property (@(posedge clk) disable iff (rst)
    pt.valid && baseline_len == '0 |-> pt.point_z == '0 && pt.point_x == '0 && pt.point_y == '0)
    else $error("zero baseline gave a nonzero point");
`endif

endmodule

### sim/disparity_to_3d_point_top_tb.sv
// Self-checking testbench for the disparity to 3D point reprojection block.
`timescale 1ns / 1ps

module disparity_to_3d_point_top_tb;
  import dtp_pkg::*;

  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
  localparam longint unsigned CFG_MAX = 64'hFFFFF;
  localparam longint unsigned LAT_MAX_POS = 64'd8388607;
  localparam longint unsigned LAT_MAX_NEG = 64'd8388608;
  localparam longint unsigned DEPTH_MAX = 64'hFFFFFF;
  localparam int PIPE_LATENCY = 26;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [23:0]        z;
    logic               v;
  } point_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dtp_pix_if pix ();
  dtp_pt_if  pt ();

  disparity_to_3d_point_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix.sink),
    .pt        (pt.source)
  );

  longint unsigned baseline_q;
  longint unsigned focal_q;
  longint unsigned offset_q;
  longint unsigned centre_x_q;
  longint unsigned centre_y_q;

  point_t pending_points[$];
  int     n_errors;
  int     n_pixels;
  int     n_points;
  int     n_settings;
  int     stall_left;
  bit     tx_quiet;
  bit     rx_quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [23:0] lateral_coord(longint unsigned pixel,
                                                longint unsigned centre,
                                                longint unsigned den);
    longint unsigned scaled;
    longint unsigned mag;
    longint unsigned q;
    scaled = pixel * 80;
    if (scaled < centre) begin
      mag = centre - scaled;
      q = (mag * baseline_q) / den;
      if (q > LAT_MAX_NEG) begin
        q = LAT_MAX_NEG;
      end
      return 24'(-q);
    end
    mag = scaled - centre;
    q = (mag * baseline_q) / den;
    if (q > LAT_MAX_POS) begin
      q = LAT_MAX_POS;
    end
    return 24'(q);
  endfunction

  function automatic point_t reproject(logic [15:0] disparity, logic [11:0] column,
                                       logic [11:0] row);
    point_t p;
    longint unsigned den;
    longint unsigned z;
    den = longint'(disparity) + offset_q;
    p = '{x: '0, y: '0, z: '0, v: 1'b0};
    if (den != 0) begin
      z = (baseline_q * focal_q) / den;
      if (z > DEPTH_MAX) begin
        z = DEPTH_MAX;
      end
      p.x = lateral_coord(column, centre_x_q, den);
      p.y = lateral_coord(row, centre_y_q, den);
      p.z = 24'(z);
      p.v = 1'b1;
    end
    return p;
  endfunction

  initial begin : point_sink
    point_t e;
    int rx_gap;
    rx_gap = 0;
    pt.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pt.valid && pt.ready) begin
        n_points++;
        if (pending_points.size() == 0) begin
          $error("Point word arrived with no pixel outstanding");
          n_errors++;
        end else begin
          e = pending_points.pop_front();
          if (pt.point_x !== e.x) begin
            $error("point_x: expected %0d, got %0d", e.x, pt.point_x);
            n_errors++;
          end
          if (pt.point_y !== e.y) begin
            $error("point_y: expected %0d, got %0d", e.y, pt.point_y);
            n_errors++;
          end
          if (pt.point_z !== e.z) begin
            $error("point_z: expected %0d, got %0d", e.z, pt.point_z);
            n_errors++;
          end
          if (pt.point_valid !== e.v) begin
            $error("point_valid: expected %0d, got %0d", e.v, pt.point_valid);
            n_errors++;
          end
        end
      end
      if (rst) begin
        pt.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pt.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pt.ready <= 1'b0;
      end else begin
        pt.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) begin
          rx_gap = pick_gap(rx_quiet);
        end
      end
    end
  end

  task automatic send_pixel(logic [15:0] disparity, logic [11:0] column, logic [11:0] row);
    int gap;
    pix.valid     <= 1'b1;
    pix.disparity <= disparity;
    pix.column    <= column;
    pix.row       <= row;
    do @(posedge clk); while (!pix.ready);
    pending_points = {pending_points, reproject(disparity, column, row)};
    n_pixels++;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_points();
    pix.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, longint unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      REG_BASELINE: baseline_q = value & CFG_MAX;
      REG_FOCAL:    focal_q = value & CFG_MAX;
      REG_DOFFS:    offset_q = value & CFG_MAX;
      REG_CX:       centre_x_q = value & CFG_MAX;
      REG_CY:       centre_y_q = value & CFG_MAX;
      default: ;
    endcase
  endtask

  task automatic set_camera(longint unsigned b, longint unsigned f, longint unsigned d,
                            longint unsigned x, longint unsigned y);
    write_reg(REG_BASELINE, b);
    write_reg(REG_FOCAL, f);
    write_reg(REG_DOFFS, d);
    write_reg(REG_CX, x);
    write_reg(REG_CY, y);
    n_settings++;
  endtask

  function automatic longint unsigned pick_reg(longint unsigned typical);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return CFG_MAX;
      2: return $urandom_range(0, 32'hFFFFF);
      default: return $urandom_range(0, typical);
    endcase
  endfunction

  task automatic test_directed();
    set_camera(0, 0, 0, 0, 0);
    send_pixel(16'd0, 12'd0, 12'd0);
    send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
    drain_points();
    set_camera(CFG_MAX, CFG_MAX, 0, CFG_MAX, CFG_MAX);
    send_pixel(16'd0, 12'd100, 12'd100);
    send_pixel(16'd1, 12'd0, 12'd0);
    send_pixel(16'd1, 12'hFFF, 12'hFFF);
    send_pixel(16'hFFFF, 12'hFFF, 12'd0);
    send_pixel(16'hFFFF, 12'd0, 12'hFFF);
    drain_points();
    set_camera(CFG_MAX, 0, CFG_MAX, 0, 0);
    send_pixel(16'd0, 12'hFFF, 12'hFFF);
    send_pixel(16'hFFFF, 12'hFFF, 12'd0);
    drain_points();
    set_camera(1920, 11200, 320, 50000, 30000);
    send_pixel(16'd800, 12'd640, 12'd360);
    send_pixel(16'd16, 12'd0, 12'd4095);
    send_pixel(16'd0, 12'd625, 12'd375);
    drain_points();
    write_reg(REG_SPARE_FIRST, CFG_MAX);
    write_reg(REG_SPARE_FIRST + 3'd1, 20'h12345);
    write_reg(REG_SPARE_LAST, 0);
    send_pixel(16'd512, 12'd2000, 12'd1000);
    send_pixel(16'd1, 12'd1, 12'd1);
    drain_points();
    write_reg(REG_FOCAL, 1);
    write_reg(REG_DOFFS, 0);
    send_pixel(16'd0, 12'd1, 12'd1);
    send_pixel(16'd3, 12'd2048, 12'd2048);
    drain_points();
  endtask

  task automatic test_random(int phases, int per_phase);
    logic [15:0] d;
    for (int ph = 0; ph < phases; ph++) begin
      set_camera(pick_reg(8000), pick_reg(30000), pick_reg(2000), pick_reg(330000),
                 pick_reg(330000));
      tx_quiet = (ph % 4 == 1);
      rx_quiet = (ph % 4 == 2);
      for (int k = 0; k < per_phase; k++) begin
        d = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(0, 16'hFFFF));
        if ($urandom_range(0, 1) == 0) begin
          d = 16'($urandom_range(0, 4096));
        end
        send_pixel(d, 12'($urandom_range(0, 12'hFFF)), 12'($urandom_range(0, 12'hFFF)));
      end
      drain_points();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    set_camera(3000, 12000, 100, 160000, 120000);
    tx_quiet = 1'b1;
    stall_left = 300;
    for (int k = 0; k < 80; k++) begin
      send_pixel(16'($urandom_range(0, 16'hFFFF)), 12'($urandom_range(0, 12'hFFF)),
                 12'($urandom_range(0, 12'hFFF)));
    end
    tx_quiet = 1'b0;
    pix.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    for (int k = 0; k < 40; k++) begin
      send_pixel(16'($urandom_range(0, 16'hFFFF)), 12'($urandom_range(0, 12'hFFF)),
                 12'($urandom_range(0, 12'hFFF)));
    end
    drain_points();
  endtask

  initial begin : stimulus
    n_errors   = 0;
    n_pixels   = 0;
    n_points   = 0;
    n_settings = 0;
    stall_left = 0;
    tx_quiet   = 1'b0;
    rx_quiet   = 1'b0;
    baseline_q = 0;
    focal_q    = 16;
    offset_q   = 0;
    centre_x_q = 0;
    centre_y_q = 0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_BASELINE;
    cfg_data      <= '0;
    pix.valid     <= 1'b0;
    pix.disparity <= '0;
    pix.column    <= '0;
    pix.row       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_pixel(16'd32, 12'd10, 12'd10);
    send_pixel(16'd0, 12'd10, 12'd10);
    drain_points();
    test_directed();
    test_backpressure();
    test_random(12, 145);
    drain_points();
    $display("Covered %0d pixels and %0d points over %0d camera settings,", n_pixels,
             n_points, n_settings);
    $display("with saturation, zero-denominator, spare-register and stall cases.");
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
